@@ hw/rtl/afe_pkg.sv @@
// Shared types, constants and the quarter-sine gain table of the audio fade envelope.
`timescale 1ns / 1ps
package afe_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int FRAME_BITS     = 24;
   localparam int MAX_CHANNELS   = 8;
   localparam int SINE_DEPTH     = 256;

   localparam int CHAN_IDX_BITS  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CHAN_CNT_BITS  = $clog2(MAX_CHANNELS + 1);
   localparam int GAIN_BITS      = 17;
   localparam int FRAC_BITS      = 16;
   localparam int POS_BITS       = $clog2(SINE_DEPTH) + FRAC_BITS;
   localparam int IDX_BITS       = POS_BITS + 1 - FRAC_BITS;
   localparam int NUM_BITS       = FRAME_BITS + POS_BITS;
   localparam int STEP_BITS      = $clog2(POS_BITS);
   localparam int SLOPE_BITS     = GAIN_BITS + FRAC_BITS;
   localparam int PROD_BITS      = SAMPLE_BITS + GAIN_BITS + 1;
   localparam int RND_BITS       = PROD_BITS - FRAC_BITS;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = FRAME_BITS;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [GAIN_BITS-1:0] UNITY_GAIN = GAIN_BITS'(65536);
   localparam logic [POS_BITS:0]    POS_FULL   = (POS_BITS + 1)'(SINE_DEPTH) << FRAC_BITS;
   localparam longint unsigned      PI_HALF_Q30 = 64'd1686629713;
   localparam longint unsigned      TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_FADE_LENGTH    = 3'd0,
      REG_TOTAL_FRAMES   = 3'd1,
      REG_CHANNEL_COUNT  = 3'd2,
      REG_CURVE_KIND     = 3'd3,
      REG_FADE_DIRECTION = 3'd4
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LEN,
      ST_OFF,
      ST_POS,
      ST_LOAD,
      ST_DIV,
      ST_CURVE,
      ST_TAB_A,
      ST_TAB_B,
      ST_SLOPE,
      ST_INTERP,
      ST_MUL,
      ST_ROUND
   } back_state_type;

   typedef struct packed {
      logic [FRAME_BITS-1:0]    fade_length;
      logic [FRAME_BITS-1:0]    total_frames;   // held at 1 or more
      logic [CHAN_CNT_BITS-1:0] channel_count;  // held in 1..MAX_CHANNELS
      logic                     curve_kind;
      logic                     fade_direction;
   } afe_cfg_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   frame_start;
      logic [FRAME_BITS-1:0]  frame;
      logic                   buffer_end;
   } afe_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } afe_qstat_type;

   typedef logic [GAIN_BITS-1:0] sine_tab_type [0:SINE_DEPTH];

   // Quarter sine in Q1.16 from an eight-term Taylor series in Q30.
   function automatic sine_tab_type build_sine_tab();
      sine_tab_type    tab;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned g;
      longint          sum;
      for (int k = 0; k <= SINE_DEPTH; k++) begin
         x    = (PI_HALF_Q30 * longint'(k)) / SINE_DEPTH;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if (n % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         g = (longint'(sum) + 8192) >> 14;
         if (g > 65536) begin
            g = 65536;
         end
         tab[k] = g[GAIN_BITS-1:0];
      end
      tab[0]          = '0;
      tab[SINE_DEPTH] = UNITY_GAIN;
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

endpackage

@@ hw/rtl/afe_csr.sv @@
// Configuration registers of the audio fade envelope.
`timescale 1ns / 1ps
module afe_csr
   import afe_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output afe_cfg_type               cfg
);

   afe_cfg_type cfg_ff;
   afe_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Clamp counts on the way in so consumers see legal values only.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_FADE_LENGTH: begin
               cfg_in.fade_length = csr_data[FRAME_BITS-1:0];
            end
            REG_TOTAL_FRAMES: begin
               if (csr_data == '0) begin
                  cfg_in.total_frames = FRAME_BITS'(1);
               end else begin
                  cfg_in.total_frames = csr_data[FRAME_BITS-1:0];
               end
            end
            REG_CHANNEL_COUNT: begin
               if (csr_data == '0) begin
                  cfg_in.channel_count = CHAN_CNT_BITS'(1);
               end else if (csr_data > CSR_DATA_BITS'(MAX_CHANNELS)) begin
                  cfg_in.channel_count = CHAN_CNT_BITS'(MAX_CHANNELS);
               end else begin
                  cfg_in.channel_count = csr_data[CHAN_CNT_BITS-1:0];
               end
            end
            REG_CURVE_KIND: begin
               cfg_in.curve_kind = csr_data[0];
            end
            REG_FADE_DIRECTION: begin
               cfg_in.fade_direction = csr_data[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fade_length    <= '0;
         cfg_ff.total_frames   <= FRAME_BITS'(1);
         cfg_ff.channel_count  <= CHAN_CNT_BITS'(1);
         cfg_ff.curve_kind     <= 1'b0;
         cfg_ff.fade_direction <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hw/rtl/afe_front.sv @@
// Front end: accepts samples, tracks frame and channel position, tags each item.
`timescale 1ns / 1ps
module afe_front
   import afe_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  afe_cfg_type                   cfg,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  afe_qstat_type                 qstat,
   output logic                          push,
   output afe_item_type                  push_item
);

   logic [FRAME_BITS-1:0]    frame_ff;
   logic [FRAME_BITS-1:0]    frame_in;
   logic [CHAN_IDX_BITS-1:0] chan_ff;
   logic [CHAN_IDX_BITS-1:0] chan_in;
   logic                     last_chan;
   logic                     last_frame;

   assign req_stall = qstat.full;
   assign push      = req_valid && !qstat.full;

   assign last_chan  = (CHAN_CNT_BITS'(chan_ff) + CHAN_CNT_BITS'(1)) >= cfg.channel_count;
   assign last_frame = ({1'b0, frame_ff} + (FRAME_BITS + 1)'(1)) >= {1'b0, cfg.total_frames};

   always_comb begin
      push_item.sample      = req_sample_in;
      push_item.frame_start = (chan_ff == '0);
      push_item.frame       = frame_ff;
      push_item.buffer_end  = last_chan && last_frame;
   end

   // Advance channel, then frame; wrap both on the buffer's last sample.
   always_comb begin
      frame_in = frame_ff;
      chan_in  = chan_ff;
      if (push) begin
         if (last_chan) begin
            chan_in = '0;
            if (last_frame) begin
               frame_in = '0;
            end else begin
               frame_in = frame_ff + FRAME_BITS'(1);
            end
         end else begin
            chan_in = chan_ff + CHAN_IDX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         chan_ff  <= '0;
      end else begin
         frame_ff <= frame_in;
         chan_ff  <= chan_in;
      end
   end

endmodule

@@ hw/rtl/afe_queue.sv @@
// Short item queue between the front end and the gain engine.
`timescale 1ns / 1ps
module afe_queue
   import afe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  afe_item_type  push_item,
   input  logic          pop,
   output afe_item_type  pop_item,
   output afe_qstat_type qstat
);

   afe_item_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QCNT_BITS-1:0] count_ff;
   logic [QCNT_BITS-1:0] count_in;

   assign pop_item    = mem_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

@@ hw/rtl/afe_back.sv @@
// Gain engine: per-frame gain by serial division and table lookup, then scale and saturate.
`timescale 1ns / 1ps
module afe_back
   import afe_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  afe_cfg_type                   cfg,
   input  afe_qstat_type                 qstat,
   input  afe_item_type                  pop_item,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                          rsp_buffer_end
);

   localparam logic signed [RND_BITS-1:0] SAT_MAX =
      {{(RND_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [RND_BITS-1:0] SAT_MIN =
      {{(RND_BITS - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

   back_state_type              state_ff;
   back_state_type              state_in;
   afe_item_type                item_ff;
   logic [FRAME_BITS-1:0]       len_ff;
   logic [FRAME_BITS-1:0]       start_ff;
   logic [FRAME_BITS-1:0]       j_ff;
   logic [FRAME_BITS-1:0]       rem_ff;
   logic [POS_BITS-1:0]         nq_ff;
   logic [STEP_BITS-1:0]        step_ff;
   logic [POS_BITS:0]           pos_ff;
   logic [GAIN_BITS-1:0]        tab_a_ff;
   logic [GAIN_BITS-1:0]        tab_b_ff;
   logic [SLOPE_BITS-1:0]       slope_ff;
   logic [GAIN_BITS-1:0]        gain_ff;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic                        rsp_valid_ff;
   logic [SAMPLE_BITS-1:0]      sample_out_ff;
   logic                        buffer_end_ff;

   logic                        out_load;
   logic [FRAME_BITS:0]         frame_diff;
   logic                        fade_hit;
   logic [NUM_BITS-1:0]         numer;
   logic [FRAME_BITS:0]         div_shift;
   logic                        div_ge;
   logic [FRAME_BITS:0]         div_sub;
   logic [IDX_BITS-1:0]         tab_idx;
   logic [IDX_BITS-1:0]         tab_idx_next;
   logic [FRAC_BITS-1:0]        pos_frac;
   logic [GAIN_BITS-1:0]        slope_diff;
   logic [SLOPE_BITS-1:0]       slope_rnd;
   logic [PROD_BITS-1:0]        rnd_sum;
   logic signed [RND_BITS-1:0]  rnd;
   logic [SAMPLE_BITS-1:0]      sat;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = sample_out_ff;
   assign rsp_buffer_end = buffer_end_ff;

   // Position inside the fade window.
   assign frame_diff = {1'b0, item_ff.frame} - {1'b0, start_ff};
   assign fade_hit   = (len_ff != '0) &&
                       (cfg.fade_direction ?
                          (!frame_diff[FRAME_BITS] && (item_ff.frame < cfg.total_frames)) :
                          (item_ff.frame < len_ff));

   assign numer = cfg.curve_kind ?
                  {j_ff, {POS_BITS{1'b0}}} :
                  NUM_BITS'({j_ff, {FRAC_BITS{1'b0}}}) + NUM_BITS'(len_ff >> 1);

   // One restoring-division step per cycle; quotient bits shift in behind the numerator.
   assign div_shift = {rem_ff, nq_ff[POS_BITS-1]};
   assign div_ge    = div_shift >= {1'b0, len_ff};
   assign div_sub   = div_shift - {1'b0, len_ff};

   assign tab_idx      = pos_ff[POS_BITS:FRAC_BITS];
   assign tab_idx_next = (tab_idx == IDX_BITS'(SINE_DEPTH)) ? tab_idx :
                         tab_idx + IDX_BITS'(1);
   assign pos_frac     = pos_ff[FRAC_BITS-1:0];
   assign slope_diff   = tab_b_ff - tab_a_ff;
   assign slope_rnd    = (slope_ff + SLOPE_BITS'(32768)) >> FRAC_BITS;

   // Round half up, then clamp to the sample range.
   assign rnd_sum = prod_ff + PROD_BITS'(32768);
   assign rnd     = rnd_sum[PROD_BITS-1:FRAC_BITS];

   always_comb begin
      if (rnd > SAT_MAX) begin
         sat = SAT_MAX[SAMPLE_BITS-1:0];
      end else if (rnd < SAT_MIN) begin
         sat = SAT_MIN[SAMPLE_BITS-1:0];
      end else begin
         sat = rnd[SAMPLE_BITS-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               state_in = pop_item.frame_start ? ST_LEN : ST_MUL;
            end
         end
         ST_LEN:    state_in = ST_OFF;
         ST_OFF:    state_in = ST_POS;
         ST_POS:    state_in = fade_hit ? ST_LOAD : ST_MUL;
         ST_LOAD:   state_in = ST_DIV;
         ST_DIV: begin
            if (step_ff == STEP_BITS'(POS_BITS - 1)) begin
               state_in = ST_CURVE;
            end
         end
         ST_CURVE:  state_in = cfg.curve_kind ? ST_TAB_A : ST_MUL;
         ST_TAB_A:  state_in = ST_TAB_B;
         ST_TAB_B:  state_in = ST_SLOPE;
         ST_SLOPE:  state_in = ST_INTERP;
         ST_INTERP: state_in = ST_MUL;
         ST_MUL:    state_in = ST_ROUND;
         ST_ROUND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop      = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE:  pop      = !qstat.empty;
         ST_ROUND: out_load = !rsp_valid_ff || !rsp_stall;
         default: begin
            pop      = 1'b0;
            out_load = 1'b0;
         end
      endcase
   end

   // Datapath registers; only the ones that matter in each state are written.
   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= pop_item;
      end
      case (state_ff)
         ST_LEN: begin
            len_ff <= (cfg.fade_length < cfg.total_frames) ? cfg.fade_length :
                      cfg.total_frames;
         end
         ST_OFF: begin
            start_ff <= cfg.total_frames - len_ff;
         end
         ST_POS: begin
            j_ff <= cfg.fade_direction ? frame_diff[FRAME_BITS-1:0] : item_ff.frame;
         end
         ST_LOAD: begin
            rem_ff  <= numer[NUM_BITS-1:POS_BITS];
            nq_ff   <= numer[POS_BITS-1:0];
            step_ff <= '0;
         end
         ST_DIV: begin
            rem_ff  <= div_ge ? div_sub[FRAME_BITS-1:0] : div_shift[FRAME_BITS-1:0];
            nq_ff   <= {nq_ff[POS_BITS-2:0], div_ge};
            step_ff <= step_ff + STEP_BITS'(1);
         end
         ST_CURVE: begin
            pos_ff <= cfg.fade_direction ? POS_FULL - {1'b0, nq_ff} : {1'b0, nq_ff};
         end
         ST_TAB_A: begin
            tab_a_ff <= SINE_TAB[tab_idx];
         end
         ST_TAB_B: begin
            tab_b_ff <= SINE_TAB[tab_idx_next];
         end
         ST_SLOPE: begin
            slope_ff <= SLOPE_BITS'(slope_diff) * SLOPE_BITS'(pos_frac);
         end
         ST_MUL: begin
            prod_ff <= $signed(item_ff.sample) * $signed({1'b0, gain_ff});
         end
         default: begin
         end
      endcase
      if (out_load) begin
         sample_out_ff <= sat;
         buffer_end_ff <= item_ff.buffer_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= UNITY_GAIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_POS && !fade_hit) begin
            gain_ff <= UNITY_GAIN;
         end else if (state_ff == ST_CURVE && !cfg.curve_kind) begin
            gain_ff <= cfg.fade_direction ? UNITY_GAIN - nq_ff[GAIN_BITS-1:0] :
                       nq_ff[GAIN_BITS-1:0];
         end else if (state_ff == ST_INTERP) begin
            // At the top of the table the fraction and the slope are both zero.
            gain_ff <= tab_a_ff + slope_rnd[GAIN_BITS-1:0];
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

@@ hw/rtl/audio_fade_envelope.sv @@
// Top level of the audio fade envelope: register block, front end, queue and gain engine.
// The gain engine works on one sample at a time; the queue keeps accepting samples
//   meanwhile until it fills. Only a frame's first sample inside a fade runs the
//   24-step serial divider; the equal-power curve adds a table lookup and
//   interpolation, and the other samples of a frame reuse the held gain.
// Reset (synchronous, active high): registers to their reset values, counters to frame 0
//   channel 0, gain to unity, queue and output register empty.
`timescale 1ns / 1ps
module audio_fade_envelope
   import afe_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   // sample input channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                          rsp_buffer_end,
   // register write port
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   afe_cfg_type   cfg;
   afe_qstat_type qstat;
   afe_item_type  push_item;
   afe_item_type  pop_item;
   logic          push;
   logic          pop;

   // Hold the fade settings; counts are clamped to legal ranges on write.
   afe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Track the frame and channel of each incoming item and flag frame starts and the
   // buffer's last sample. Stall only when the queue is full.
   afe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample_in (req_sample_in),
      .qstat         (qstat),
      .push          (push),
      .push_item     (push_item)
   );

   // Buffer tagged items so the front end keeps taking samples while the engine
   // works out a frame's gain.
   afe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .qstat     (qstat)
   );

   // At each frame start, form the gain (division plus optional sine interpolation);
   // scale every sample of the frame, round, saturate and drive the output register.
   afe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .qstat          (qstat),
      .pop_item       (pop_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_buffer_end (rsp_buffer_end)
   );

endmodule

@@ hw/rtl/afe_checker.sv @@
// Port-level checks of the audio fade envelope, bound to its top level.
`timescale 1ns / 1ps
module afe_checker
   import afe_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input logic                          rsp_buffer_end
);

   // Queue, engine holding register and output register.
   localparam int MAX_INFLIGHT = QUEUE_DEPTH + 2;
   localparam int PEND_BITS    = $clog2(MAX_INFLIGHT + 2);

   logic [PEND_BITS-1:0] pend_ff;
   logic                 in_acc;
   logic                 out_acc;

   assign in_acc  = req_valid && !req_stall;
   assign out_acc = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else if (in_acc && !out_acc) begin
         pend_ff <= pend_ff + PEND_BITS'(1);
      end else if (out_acc && !in_acc) begin
         pend_ff <= pend_ff - PEND_BITS'(1);
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_out) &&
                                 $stable(rsp_buffer_end))
      else $error("stalled result changed or dropped");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != '0)
      else $error("result without an accepted item");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= PEND_BITS'(MAX_INFLIGHT))
      else $error("more items in flight than the block can hold");

endmodule

bind audio_fade_envelope afe_checker u_afe_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sample_out (rsp_sample_out),
   .rsp_buffer_end (rsp_buffer_end)
);

@@ test/audio_fade_envelope_test.sv @@
// Self-checking testbench for the audio fade envelope: directed and random buffers.
`timescale 1ns / 1ps
module audio_fade_envelope_test;
   import afe_pkg::*;

   localparam int      CLOCK_HALF    = 4;
   localparam longint  CYCLE_LIMIT   = 1_000_000;
   localparam int      RANDOM_ITEMS  = 1600;
   localparam int      MAX_WAIT      = 10;
   localparam int      IDLE_CYCLES   = 4;
   localparam int      SETTLE_CYCLES = 40;
   localparam int      PRINT_LIMIT   = 200;

   localparam longint unsigned FULL_GAIN  = 65536;
   localparam longint unsigned SINE_FULL  = longint'(SINE_DEPTH) << FRAC_BITS;
   localparam longint unsigned FRAME_MASK = (64'd1 << FRAME_BITS) - 1;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // Indexes past the register list; writes there must change nothing.
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_FIRST = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_LAST  = 3'd7;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          buffer_end;
   } scaled_item_type;

   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          req_valid      = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample_in  = '0;
   logic                          rsp_valid;
   logic                          rsp_stall      = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out;
   logic                          rsp_buffer_end;
   logic                          csr_valid      = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index      = '0;
   logic [CSR_DATA_BITS-1:0]      csr_data       = '0;

   // Register mirror, at reset values.
   logic [CSR_DATA_BITS-1:0] cfg_fade_len = '0;
   logic [CSR_DATA_BITS-1:0] cfg_total    = 1;
   logic [CSR_DATA_BITS-1:0] cfg_chans    = 1;
   logic                     cfg_curve    = 1'b0;
   logic                     cfg_dir      = 1'b0;

   // Position and gain of the envelope model.
   longint unsigned frame_pos = 0;
   longint unsigned chan_pos  = 0;
   longint unsigned held_gain = FULL_GAIN;

   longint unsigned quarter_sine [0:SINE_DEPTH];

   scaled_item_type pending_scaled_q [$];
   scaled_item_type oldest;

   longint cycle_count = 0;
   int     error_count = 0;
   int     sink_wait   = 0;
   bit     source_calm = 1'b0;
   bit     sink_calm   = 1'b0;

   audio_fade_envelope DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_buffer_end (rsp_buffer_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Quarter sine in Q1.16: eight Taylor terms in Q30, magnitudes summed with
   // alternating sign, then rounded to nearest at 16 fraction bits. Pin both ends.
   initial begin : build_quarter_sine
      longint unsigned x;
      longint unsigned x_sq;
      longint unsigned term;
      longint unsigned g;
      longint          acc;
      for (int k = 0; k <= SINE_DEPTH; k++) begin
         x    = (PI_HALF_Q30 * longint'(k)) / SINE_DEPTH;
         x_sq = (x * x) >> 30;
         term = x;
         acc  = longint'(x);
         for (int n = 1; n <= 7; n++) begin
            term = ((term * x_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
            acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
         end
         if (acc < 0) begin
            acc = 0;
         end
         g = (longint'(acc) + 8192) >> 14;
         quarter_sine[k] = (g > FULL_GAIN) ? FULL_GAIN : g;
      end
      quarter_sine[0]          = 0;
      quarter_sine[SINE_DEPTH] = FULL_GAIN;
   end

   task automatic report_mismatch(input string what);
      if (error_count < PRINT_LIMIT) begin
         $display("MISMATCH cycle %0d: %s", cycle_count, what);
      end
      error_count++;
   endtask

   // Zero frames counts as one; channel count is held to 1..MAX_CHANNELS.
   function automatic longint unsigned effective_frames();
      return (cfg_total == '0) ? 1 : longint'(cfg_total);
   endfunction

   function automatic longint unsigned effective_channels();
      if (cfg_chans == '0) begin
         return 1;
      end
      if (cfg_chans > MAX_CHANNELS) begin
         return MAX_CHANNELS;
      end
      return cfg_chans;
   endfunction

   // Gain of one frame in Q1.16. The fade span is clipped to the buffer; frames
   // outside the span, and every frame with a zero span, get unity.
   function automatic longint unsigned envelope_gain(input longint unsigned frame,
                                                     input longint unsigned frames);
      longint unsigned span;
      longint unsigned j;
      longint unsigned pos;
      longint unsigned idx;
      longint unsigned frac;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned ramp;
      span = cfg_fade_len;
      if (span > frames) begin
         span = frames;
      end
      if (span == 0) begin
         return FULL_GAIN;
      end
      if (cfg_dir) begin
         if (frame < frames - span || frame >= frames) begin
            return FULL_GAIN;
         end
         j = frame - (frames - span);
      end else begin
         if (frame >= span) begin
            return FULL_GAIN;
         end
         j = frame;
      end
      if (cfg_curve) begin
         // Table position in Q16; fade-out walks the table backward.
         pos = (j * SINE_FULL) / span;
         if (cfg_dir) begin
            pos = SINE_FULL - pos;
         end
         idx  = pos >> FRAC_BITS;
         frac = pos & 64'hFFFF;
         if (idx >= SINE_DEPTH) begin
            return quarter_sine[SINE_DEPTH];
         end
         lo = quarter_sine[idx];
         hi = quarter_sine[idx + 1];
         return (lo + (((hi - lo) * frac + 32768) >> 16)) & 64'hFFFF_FFFF;
      end
      ramp = ((j * 65536 + span / 2) / span) & 64'hFFFF_FFFF;
      return cfg_dir ? FULL_GAIN - ramp : ramp;
   endfunction

   // Scale one sample and advance the frame and channel counters.
   task automatic predict_scaled_sample(input logic signed [SAMPLE_BITS-1:0] s,
                                        output scaled_item_type r);
      longint unsigned frames;
      longint unsigned chans;
      longint          prod;
      longint          q;
      frames = effective_frames();
      chans  = effective_channels();
      // The gain is formed only at a frame's first sample and held for the rest.
      if (chan_pos == 0) begin
         held_gain = envelope_gain(frame_pos, frames);
      end
      prod = longint'(s) * longint'(held_gain);
      // Round to nearest, ties toward plus infinity.
      if (prod >= 0) begin
         q = (prod + 32768) >>> 16;
      end else begin
         q = -((-prod + 32767) >>> 16);
      end
      if (q > SAMPLE_MAX) begin
         q = SAMPLE_MAX;
      end
      if (q < SAMPLE_MIN) begin
         q = SAMPLE_MIN;
      end
      r.sample     = q[SAMPLE_BITS-1:0];
      r.buffer_end = 1'b0;
      // A channel at or past the count ends the frame; a frame at or past the
      // last one ends the buffer.
      if (chan_pos + 1 >= chans) begin
         chan_pos = 0;
         if (frame_pos + 1 >= frames) begin
            r.buffer_end = 1'b1;
            frame_pos    = 0;
         end else begin
            frame_pos = (frame_pos + 1) & FRAME_MASK;
         end
      end else begin
         chan_pos++;
      end
   endtask

   // Offer one sample after a random gap and hold it until accepted. Leave
   // valid high so the next item can follow back to back.
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
      int              gap;
      scaled_item_type want;
      gap = source_calm ? 0 : $urandom_range(0, MAX_WAIT);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= s;
      predict_scaled_sample(s, want);
      pending_scaled_q.push_back(want);
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   // Drop valid and hold until every expected result has come back.
   task automatic wait_until_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_scaled_q.size() != 0) @(negedge clock);
      repeat (IDLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [CSR_DATA_BITS-1:0]  data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         REG_FADE_LENGTH:    cfg_fade_len = data;
         REG_TOTAL_FRAMES:   cfg_total    = data;
         REG_CHANNEL_COUNT:  cfg_chans    = data;
         REG_CURVE_KIND:     cfg_curve    = data[0];
         REG_FADE_DIRECTION: cfg_dir      = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Result side: check each accepted item against the oldest expectation,
   // then draw how long to stall the next one.
   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_scaled_q.size() == 0) begin
            report_mismatch($sformatf("unexpected item, sample_out %0d", rsp_sample_out));
         end else begin
            oldest = pending_scaled_q.pop_front();
            if (rsp_sample_out !== oldest.sample) begin
               report_mismatch($sformatf("sample_out %0d, expected %0d",
                                         rsp_sample_out, oldest.sample));
            end
            if (rsp_buffer_end !== oldest.buffer_end) begin
               report_mismatch($sformatf("buffer_end %0b, expected %0b",
                                         rsp_buffer_end, oldest.buffer_end));
            end
         end
         sink_wait <= sink_calm ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (rsp_valid === 1'b1 && sink_wait != 0) begin
         sink_wait <= sink_wait - 1;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= (sink_wait != 0);
   end

   // Registers at reset: no fade, one frame of one channel, so every item
   // passes unchanged and ends the buffer.
   task automatic test_reset_passthrough();
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample('0);
      send_sample(-1);
      wait_until_idle();
   endtask

   // All four curve and direction pairs over a three-frame fade; frames carry
   // over from one pair to the next.
   task automatic test_fade_shapes();
      write_register(REG_FADE_LENGTH, 3);
      write_register(REG_TOTAL_FRAMES, 3);
      for (int shape = 0; shape < 4; shape++) begin
         write_register(REG_CURVE_KIND, shape[0]);
         write_register(REG_FADE_DIRECTION, shape[1]);
         send_sample(SAMPLE_MAX);
         send_sample(SAMPLE_MIN);
         wait_until_idle();
      end
   endtask

   // Longest fade on a two-frame buffer: clip it. Upper bits of the curve and
   // direction words must be ignored. The frame counter starts past the end.
   task automatic test_clipped_fade();
      write_register(REG_FADE_LENGTH, '1);
      write_register(REG_TOTAL_FRAMES, 2);
      write_register(REG_CURVE_KIND, '1);
      write_register(REG_FADE_DIRECTION, 24'h000003);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      wait_until_idle();
   endtask

   // Zero frames and zero channels count as one; a huge channel count clamps.
   // Then shrink the channel count mid-frame so the frame ends early.
   task automatic test_count_clamps();
      write_register(REG_FADE_LENGTH, '0);
      write_register(REG_TOTAL_FRAMES, '0);
      write_register(REG_CHANNEL_COUNT, '0);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      wait_until_idle();
      write_register(REG_TOTAL_FRAMES, 1);
      write_register(REG_CHANNEL_COUNT, '1);
      repeat (5) send_sample($urandom);
      wait_until_idle();
      write_register(REG_CHANNEL_COUNT, 2);
      send_sample(SAMPLE_MAX);
      wait_until_idle();
   endtask

   // Writes past the register list are dropped.
   task automatic test_ignored_index();
      write_register(REG_FADE_LENGTH, 2);
      write_register(REG_TOTAL_FRAMES, 2);
      for (int idx = REG_SPARE_FIRST; idx <= REG_SPARE_LAST; idx++) begin
         write_register(idx, '1);
      end
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      wait_until_idle();
   endtask

   // Phases of random setup, mostly whole small buffers so fades complete,
   // with huge sizes, partial buffers and junk register writes mixed in.
   task automatic test_random_buffers();
      int                            sent;
      int                            phase_items;
      logic [CSR_DATA_BITS-1:0]      total_pick;
      logic [CSR_DATA_BITS-1:0]      chan_pick;
      logic [CSR_DATA_BITS-1:0]      len_pick;
      logic signed [SAMPLE_BITS-1:0] s;
      longint unsigned               frames;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         source_calm = ($urandom_range(0, 3) == 0);
         sink_calm   = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0:       total_pick = '0;
            1:       total_pick = '1;
            2:       total_pick = $urandom;
            default: total_pick = $urandom_range(1, 24);
         endcase
         case ($urandom_range(0, 7))
            0:       chan_pick = '0;
            1:       chan_pick = $urandom_range(MAX_CHANNELS + 1, 15);
            2:       chan_pick = $urandom;
            default: chan_pick = $urandom_range(1, MAX_CHANNELS);
         endcase
         case ($urandom_range(0, 7))
            0:       len_pick = '0;
            1:       len_pick = '1;
            2:       len_pick = $urandom;
            3:       len_pick = total_pick + $urandom_range(0, 4);
            default: len_pick = $urandom_range(1, 24);
         endcase
         // Skip some writes so old settings and counters carry over.
         if ($urandom_range(0, 7) != 0) write_register(REG_TOTAL_FRAMES, total_pick);
         if ($urandom_range(0, 7) != 0) write_register(REG_CHANNEL_COUNT, chan_pick);
         if ($urandom_range(0, 7) != 0) write_register(REG_FADE_LENGTH, len_pick);
         if ($urandom_range(0, 3) != 0) write_register(REG_CURVE_KIND, $urandom);
         if ($urandom_range(0, 3) != 0) write_register(REG_FADE_DIRECTION, $urandom);
         if ($urandom_range(0, 5) == 0) begin
            write_register($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST), $urandom);
         end
         frames = effective_frames();
         if ($urandom_range(0, 4) == 0) begin
            phase_items = $urandom_range(1, 12);
         end else if (frames <= 24) begin
            phase_items = frames * effective_channels() * $urandom_range(1, 3)
                          + $urandom_range(0, 3);
         end else begin
            phase_items = $urandom_range(20, 120);
         end
         repeat (phase_items) begin
            case ($urandom_range(0, 9))
               0:       s = SAMPLE_MAX;
               1:       s = SAMPLE_MIN;
               2:       s = '0;
               3:       s = -1;
               default: s = $urandom;
            endcase
            send_sample(s);
         end
         sent += phase_items;
         wait_until_idle();
      end
      source_calm = 1'b0;
      sink_calm   = 1'b0;
   endtask

   initial begin
      // Hold reset, then release it at a falling edge.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_passthrough();
      test_fade_shapes();
      test_clipped_fade();
      test_count_clamps();
      test_ignored_index();
      test_random_buffers();

      // Drain, then give a stray late item time to show up.
      wait_until_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
